/* rtl/nand_controller_command_sequencer_macros.svh */
// Assertion macros shared by the command sequencer modules.
// Each use expects signals named clk and arst_n in the enclosing module.
`ifndef NAND_CONTROLLER_COMMAND_SEQUENCER_MACROS_SVH
`define NAND_CONTROLLER_COMMAND_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define NCS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ncs: same-cycle check failed");
`define NCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ncs: next-cycle check failed");
`else
`define NCS_ASSERT_IMPL(label, ante, cons)
`define NCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/ncs_pkg.sv */
// Types and constants of the NAND controller command sequencer.
// No dependencies; used by ncs_engine and the top level.
package ncs_pkg;

	typedef struct packed {
		logic [1:0]  mode;
		logic [12:0] byte_offset;
		logic [2:0]  access_size;
		logic [31:0] write_data;
	} ncs_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
	} ncs_rsp_t;

	typedef enum logic [1:0] {
		TK_NONE    = 2'd0,
		TK_TIMEOUT = 2'd1,
		TK_BUSY    = 2'd2
	} timer_kind_t;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Word indexes of the registers with special behavior.
	localparam int IX_CTL    = 0;
	localparam int IX_INT    = 2;
	localparam int IX_INT_EN = 3;
	localparam int IX_STATUS = 6;
	localparam int IX_CMD    = 7;
	localparam int IX_TOCTRL = 15;
	localparam int IX_TOSTAT = 17;

	localparam logic [12:0] OFF_CTL    = 13'h000;
	localparam logic [12:0] OFF_INT    = 13'h008;
	localparam logic [12:0] OFF_STATUS = 13'h018;
	localparam logic [12:0] OFF_TOSTAT = 13'h044;

	localparam logic [31:0] CTL_MASK     = 32'h0000_032F;
	localparam logic [31:0] INT_TIMEOUT  = 32'h0000_0002;
	localparam logic [31:0] INT_CMD      = 32'h0000_0004;
	localparam logic [31:0] STAT_BUSY_RB = 32'h0000_0080;
	localparam logic [31:0] TOSTAT_CMD   = 32'h0000_0001;
	localparam logic [31:0] TOSTAT_DATA  = 32'h0000_0002;

	localparam logic [31:0] CMD_RESET      = 32'h0000_0000;
	localparam logic [31:0] CMD_PROGRAM    = 32'h0000_0008;
	localparam logic [31:0] CMD_RANDOM_IN  = 32'h0000_0085;
	localparam logic [31:0] CMD_PROG_CONF  = 32'h0000_0010;
	localparam logic [31:0] CMD_ERASE_CONF = 32'h0000_00D0;
	localparam logic [31:0] CMD_READ_ID    = 32'h0000_0090;
	localparam logic [31:0] CMD_STATUS     = 32'h0000_0070;
	localparam logic [31:0] CMD_RANDOM_OUT = 32'h0000_0005;
	localparam logic [31:0] CMD_READ_2     = 32'h0000_0020;
	localparam logic [31:0] CMD_READ_CONF  = 32'h0000_0030;

	localparam logic [39:0] T_CYCLE   = 40'd21;
	localparam logic [39:0] T_DEFAULT = 40'd1000000000;
	localparam logic [39:0] T_RST     = 40'd200000;
	localparam logic [39:0] T_SHORT   = 40'd50000;
	localparam logic [39:0] T_PROG    = 40'd1200000;
	localparam logic [39:0] T_ERASE   = 40'd50000000;

	function automatic logic [39:0] busy_length(input logic [31:0] cmd);
		logic [39:0] len;
		case (cmd) inside
			CMD_RESET: len = T_RST;
			CMD_PROGRAM, CMD_RANDOM_IN, CMD_PROG_CONF: len = T_PROG;
			CMD_ERASE_CONF: len = T_ERASE;
			default: len = T_SHORT;
		endcase
		return len;
	endfunction

endpackage

/* rtl/ncs_engine.sv */
// Register file, command latch and timer of the command sequencer.
// Applies one request per step; depends on ncs_pkg and the macro header.
`include "nand_controller_command_sequencer_macros.svh"

module ncs_engine #(
	parameter int NUM_REGS = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             socket_populated,
	input  ncs_pkg::ncs_req_t req,
	output ncs_pkg::ncs_rsp_t rsp
);

	localparam int IW = $clog2(NUM_REGS);

	logic [31:0]          rf_q [NUM_REGS];
	logic [31:0]          rf_d [NUM_REGS];
	logic [31:0]          lcmd_q, lcmd_d;
	logic                 busy_q, busy_d;
	logic                 phase2_q, phase2_d;
	ncs_pkg::timer_kind_t kind_q, kind_d;
	logic [39:0]          remain_q, remain_d;

	logic          in_win;
	logic [IW-1:0] word_ix;
	logic [31:0]   ctl_new;
	logic [31:0]   rd_word;
	logic [31:0]   rd_shift;
	logic [31:0]   rd;
	logic [39:0]   elapsed;

	always_comb begin
		rf_d     = rf_q;
		lcmd_d   = lcmd_q;
		busy_d   = busy_q;
		phase2_d = phase2_q;
		kind_d   = kind_q;
		remain_d = remain_q;
		rd       = '0;

		in_win   = req.byte_offset[12:2] < 11'(NUM_REGS);
		word_ix  = req.byte_offset[IW+1:2];
		ctl_new  = req.write_data & ncs_pkg::CTL_MASK;
		elapsed  = 40'(req.write_data);

		rd_word = in_win ? rf_q[word_ix] : '0;
		if (req.byte_offset == ncs_pkg::OFF_STATUS && socket_populated && busy_q) begin
			rd_word[0] = 1'b1;
		end
		rd_shift = rd_word >> {req.byte_offset[1:0], 3'b000};

		if (step) begin
			case (req.mode)
				ncs_pkg::MODE_WRITE: begin
					if (in_win) begin
						if (req.byte_offset == ncs_pkg::OFF_INT) begin
							rf_d[ncs_pkg::IX_INT] = rf_q[ncs_pkg::IX_INT]
								& ~(req.write_data & 32'h7);
						end else if (req.byte_offset == ncs_pkg::OFF_TOSTAT) begin
							rf_d[ncs_pkg::IX_TOSTAT] = rf_q[ncs_pkg::IX_TOSTAT]
								& ~(req.write_data & 32'h3);
						end else if (req.byte_offset == ncs_pkg::OFF_CTL) begin
							rf_d[ncs_pkg::IX_CTL] = ctl_new;
							if (ctl_new[0] && !rf_q[ncs_pkg::IX_CTL][0]) begin
								// RUN rises: latch the command and start it.
								lcmd_d   = rf_q[ncs_pkg::IX_CMD];
								phase2_d = 1'b0;
								kind_d   = ncs_pkg::TK_NONE;
								remain_d = '0;
								if (!socket_populated) begin
									kind_d = ncs_pkg::TK_TIMEOUT;
									if (rf_q[ncs_pkg::IX_TOCTRL] != '0) begin
										remain_d = 40'(rf_q[ncs_pkg::IX_TOCTRL])
											* ncs_pkg::T_CYCLE;
									end else begin
										remain_d = ncs_pkg::T_DEFAULT;
									end
								end else if (ctl_new[3:1] == 3'b000) begin
									// No transfer type: the command completes at once.
									rf_d[ncs_pkg::IX_CTL][0] = 1'b0;
									rf_d[ncs_pkg::IX_INT] = rf_q[ncs_pkg::IX_INT]
										| ncs_pkg::INT_CMD;
								end else begin
									busy_d = 1'b1;
									rf_d[ncs_pkg::IX_STATUS] = ncs_pkg::STAT_BUSY_RB;
									kind_d   = ncs_pkg::TK_BUSY;
									remain_d = ncs_pkg::busy_length(rf_q[ncs_pkg::IX_CMD]);
								end
							end else if (!ctl_new[0] && rf_q[ncs_pkg::IX_CTL][0]) begin
								// RUN falls: abort whatever is in flight.
								kind_d   = ncs_pkg::TK_NONE;
								remain_d = '0;
								busy_d   = 1'b0;
								phase2_d = 1'b0;
								rf_d[ncs_pkg::IX_STATUS] = '0;
							end
						end else begin
							rf_d[word_ix] = req.write_data;
						end
					end
				end
				ncs_pkg::MODE_READ: begin
					case (req.access_size)
						3'd0: rd = '0;
						3'd1: rd = {24'd0, rd_shift[7:0]};
						3'd2: rd = {16'd0, rd_shift[15:0]};
						3'd3: rd = {8'd0, rd_shift[23:0]};
						default: rd = rd_shift;
					endcase
				end
				ncs_pkg::MODE_TICK: begin
					if (kind_q != ncs_pkg::TK_NONE) begin
						if (elapsed < remain_q) begin
							remain_d = remain_q - elapsed;
						end else begin
							kind_d   = ncs_pkg::TK_NONE;
							remain_d = '0;
							if (kind_q == ncs_pkg::TK_TIMEOUT) begin
								rf_d[ncs_pkg::IX_CTL][0] = 1'b0;
								rf_d[ncs_pkg::IX_TOSTAT] = rf_q[ncs_pkg::IX_TOSTAT]
									| ncs_pkg::TOSTAT_CMD;
								rf_d[ncs_pkg::IX_INT] = rf_q[ncs_pkg::IX_INT]
									| ncs_pkg::INT_TIMEOUT;
							end else if (socket_populated) begin
								if (!phase2_q && lcmd_q == ncs_pkg::CMD_PROGRAM) begin
									// Program data moves in a second busy phase.
									phase2_d = 1'b1;
									busy_d   = 1'b1;
									rf_d[ncs_pkg::IX_STATUS] = ncs_pkg::STAT_BUSY_RB;
									kind_d   = ncs_pkg::TK_BUSY;
									remain_d = ncs_pkg::T_PROG;
								end else begin
									if (!phase2_q) begin
										case (lcmd_q) inside
											ncs_pkg::CMD_READ_ID, ncs_pkg::CMD_STATUS,
											ncs_pkg::CMD_RANDOM_OUT, ncs_pkg::CMD_READ_2,
											ncs_pkg::CMD_READ_CONF, ncs_pkg::CMD_RANDOM_IN:
												rf_d[ncs_pkg::IX_TOSTAT] =
													rf_q[ncs_pkg::IX_TOSTAT]
													| ncs_pkg::TOSTAT_DATA;
											default: ;
										endcase
									end
									phase2_d = 1'b0;
									busy_d   = 1'b0;
									rf_d[ncs_pkg::IX_STATUS] = '0;
									rf_d[ncs_pkg::IX_CTL][0] = 1'b0;
									rf_d[ncs_pkg::IX_INT] = rf_q[ncs_pkg::IX_INT]
										| ncs_pkg::INT_CMD;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end

		rsp.read_data = rd;
		rsp.irq       = |(rf_d[ncs_pkg::IX_INT] & rf_d[ncs_pkg::IX_INT_EN]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
			lcmd_q   <= '0;
			busy_q   <= 1'b0;
			phase2_q <= 1'b0;
			kind_q   <= ncs_pkg::TK_NONE;
			remain_q <= '0;
		end else if (step) begin
			rf_q     <= rf_d;
			lcmd_q   <= lcmd_d;
			busy_q   <= busy_d;
			phase2_q <= phase2_d;
			kind_q   <= kind_d;
			remain_q <= remain_d;
		end
	end

	`NCS_ASSERT_IMPL(a_idle_timer_zero, kind_q == ncs_pkg::TK_NONE, remain_q == 40'd0)
	`NCS_ASSERT_IMPL(a_phase2_is_program, phase2_q, lcmd_q == ncs_pkg::CMD_PROGRAM)
	`NCS_ASSERT_IMPL(a_phase2_no_timeout, phase2_q, kind_q != ncs_pkg::TK_TIMEOUT)

endmodule

/* rtl/nand_controller_command_sequencer.sv */
// NAND controller register block and command sequencer, top level.
// A request is taken into the input register, and its result is then
// written to the response register. Throughput: one request per cycle while rsp_ready
// holds; the whole update of registers and timer fits between those two registers.
// Reset: asynchronous, active low; clears register file, timer and socket flag.
`include "nand_controller_command_sequencer_macros.svh"

module nand_controller_command_sequencer #(
	parameter int NUM_REGS = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ncs_pkg::ncs_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ncs_pkg::ncs_rsp_t rsp,
	input  logic              cfg_write_enable,
	input  logic              cfg_write_data
);

	ncs_pkg::ncs_req_t req_s1;
	logic              s1_valid_q;
	ncs_pkg::ncs_rsp_t rsp_q;
	logic              rsp_valid_q;
	ncs_pkg::ncs_rsp_t rsp_next;
	logic              socket_q;
	logic              advance;

	// The held request is applied when the response register can take its result.
	assign advance   = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			socket_q <= 1'b0;
		end else if (cfg_write_enable) begin
			socket_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	ncs_engine #(
		.NUM_REGS(NUM_REGS)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.socket_populated(socket_q),
		.req             (req_s1),
		.rsp             (rsp_next)
	);

	`NCS_ASSERT_IMPL(a_ready_when_out_free, !rsp_valid_q, req_ready)
	`NCS_ASSERT_NEXT(a_step_fills_out, advance, rsp_valid_q)
	`NCS_ASSERT_IMPL(a_hold_when_full, s1_valid_q && rsp_valid_q && !rsp_ready, !req_ready)

endmodule
